// ----- design/hrbd_pkg.sv -----
// Shared types and constants for the heart rate beat detector.
// No dependencies; imported by every module of the block.
package hrbd_pkg;

   localparam int THRESH_BITS   = 12;
   localparam int INTERVAL_BITS = 16;
   localparam int QUOT_BITS     = 23;
   localparam int CNT_BITS      = $clog2(QUOT_BITS);
   localparam int RSP_DATA_BITS = 48;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 16;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [QUOT_BITS-1:0] RATE_NUMERATOR = 23'd6000000;

   localparam logic [THRESH_BITS-1:0]   UPPER_RESET   = 12'd500;
   localparam logic [THRESH_BITS-1:0]   LOWER_RESET   = 12'd400;
   localparam logic [INTERVAL_BITS-1:0] MIN_INT_RESET = 16'd600;
   localparam logic [INTERVAL_BITS-1:0] MAX_INT_RESET = 16'd900;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_UPPER_THRESHOLD = 2'd0,
      CSR_LOWER_THRESHOLD = 2'd1,
      CSR_MIN_INTERVAL    = 2'd2,
      CSR_MAX_INTERVAL    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [THRESH_BITS-1:0]   upper_threshold;
      logic [THRESH_BITS-1:0]   lower_threshold;
      logic [INTERVAL_BITS-1:0] min_interval_ms;
      logic [INTERVAL_BITS-1:0] max_interval_ms;
   } cfg_type;

   typedef struct packed {
      logic                     beat;
      logic                     latched;
      logic                     do_div;
      logic [INTERVAL_BITS-1:0] interval;
   } cmd_type;

   typedef struct packed {
      logic                 full;
      logic                 empty;
      logic [QCNT_BITS-1:0] count;
   } queue_status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIVIDE,
      BK_WRITE
   } back_state_type;

endpackage

// ----- design/hrbd_front.sv -----
// Front end: threshold hysteresis, beat timing and interval clamp.
// Depends on hrbd_pkg; pushes one command per accepted sample into hrbd_queue.
module hrbd_front #(
   parameter int SAMPLE_BITS = 12,
   parameter int TIME_BITS   = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [SAMPLE_BITS-1:0] sample,
   input  logic [TIME_BITS-1:0]   time_ms,
   input  hrbd_pkg::cfg_type      cfg,
   output logic                   push,
   output hrbd_pkg::cmd_type      cmd
);
   import hrbd_pkg::*;

   localparam int CMP_BITS = 16;

   logic                 latch_ff, latch_in;
   logic                 seen_ff, seen_in;
   logic [TIME_BITS-1:0] last_ff, last_in;

   logic [CMP_BITS-1:0]  sample_x;
   logic                 beat;
   logic                 latch_set;
   logic [TIME_BITS-1:0] interval;
   logic [TIME_BITS-1:0] max_x;
   logic [TIME_BITS-1:0] lo_clamp;
   logic [INTERVAL_BITS-1:0] clamped;

   always_comb begin
      sample_x  = CMP_BITS'(sample);
      beat      = (sample_x > CMP_BITS'(cfg.upper_threshold)) && !latch_ff;
      latch_set = beat || latch_ff;
      latch_in  = latch_set && !(sample_x < CMP_BITS'(cfg.lower_threshold));
      seen_in   = seen_ff || beat;
      last_in   = beat ? time_ms : last_ff;

      interval  = time_ms - last_ff;
      max_x     = TIME_BITS'(cfg.max_interval_ms);
      lo_clamp  = (interval < max_x) ? interval : max_x;
      clamped   = INTERVAL_BITS'(lo_clamp);
      if (clamped < cfg.min_interval_ms) begin
         clamped = cfg.min_interval_ms;
      end

      push         = accept;
      cmd.beat     = beat;
      cmd.latched  = latch_in;
      cmd.do_div   = beat && seen_ff && (interval != '0);
      cmd.interval = clamped;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latch_ff <= 1'b0;
         seen_ff  <= 1'b0;
         last_ff  <= '0;
      end else if (accept) begin
         latch_ff <= latch_in;
         seen_ff  <= seen_in;
         last_ff  <= last_in;
      end
   end

endmodule

// ----- design/hrbd_queue.sv -----
// Short command queue between the front end and the rate back end.
// Depends on hrbd_pkg for the command and status types.
module hrbd_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  hrbd_pkg::cmd_type          push_cmd,
   input  logic                       pop,
   output hrbd_pkg::cmd_type          head,
   output hrbd_pkg::queue_status_type status
);
   import hrbd_pkg::*;

   cmd_type              mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
      status.count = count_ff;
      status.full  = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
      status.empty = (count_ff == '0);
      head         = mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

endmodule

// ----- design/hrbd_back.sv -----
// Back end: restoring divider for the rate and the result register.
// Depends on hrbd_pkg; drains commands from hrbd_queue.
module hrbd_back (
   input  logic                                clock,
   input  logic                                reset,
   input  hrbd_pkg::cmd_type                   head,
   input  hrbd_pkg::queue_status_type          qstat,
   output logic                                pop,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_beat,
   output logic                                rsp_latched,
   output logic                                rsp_updated,
   output logic [hrbd_pkg::INTERVAL_BITS-1:0]  rsp_interval,
   output logic [hrbd_pkg::QUOT_BITS-1:0]      rsp_bpm,
   output logic                                rsp_rate_valid
);
   import hrbd_pkg::*;

   back_state_type state_ff, state_in;

   cmd_type                  cmd_ff;
   logic [INTERVAL_BITS-1:0] rem_ff;
   logic [QUOT_BITS-1:0]     num_ff;
   logic [QUOT_BITS-1:0]     quo_ff;
   logic [CNT_BITS-1:0]      cnt_ff;

   logic                     valid_ff, valid_in;
   logic                     beat_ff, latched_ff, updated_ff, seen_ff;
   logic [INTERVAL_BITS-1:0] interval_ff;
   logic [QUOT_BITS-1:0]     bpm_ff;

   logic                     out_free;
   logic                     step;
   logic                     wr_plain;
   logic                     wr_rate;
   logic [INTERVAL_BITS:0]   trial;
   logic                     fits;

   assign out_free = !valid_ff || rsp_ready;
   assign trial    = {rem_ff, num_ff[QUOT_BITS-1]};
   assign fits     = trial >= {1'b0, cmd_ff.interval};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!qstat.empty && head.do_div) begin
               state_in = (head.interval != '0) ? BK_DIVIDE : BK_WRITE;
            end
         end
         BK_DIVIDE: begin
            if (cnt_ff == '0) begin
               state_in = BK_WRITE;
            end
         end
         BK_WRITE: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      pop      = 1'b0;
      step     = 1'b0;
      wr_plain = 1'b0;
      wr_rate  = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            pop      = !qstat.empty && (head.do_div || out_free);
            wr_plain = pop && !head.do_div;
         end
         BK_DIVIDE: step    = 1'b1;
         BK_WRITE:  wr_rate = out_free;
         default: ;
      endcase
      valid_in = valid_ff;
      if (wr_plain || wr_rate) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cmd_ff <= head;
         rem_ff <= '0;
         num_ff <= RATE_NUMERATOR;
         quo_ff <= RATE_NUMERATOR;
         cnt_ff <= CNT_BITS'(QUOT_BITS - 1);
      end else if (step) begin
         rem_ff <= fits ? INTERVAL_BITS'(trial - {1'b0, cmd_ff.interval})
                        : INTERVAL_BITS'(trial);
         num_ff <= {num_ff[QUOT_BITS-2:0], 1'b0};
         quo_ff <= {quo_ff[QUOT_BITS-2:0], fits};
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= BK_IDLE;
         valid_ff    <= 1'b0;
         interval_ff <= '0;
         bpm_ff      <= '0;
         seen_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         if (wr_rate) begin
            interval_ff <= cmd_ff.interval;
            bpm_ff      <= quo_ff;
            seen_ff     <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_plain) begin
         beat_ff    <= head.beat;
         latched_ff <= head.latched;
         updated_ff <= 1'b0;
      end else if (wr_rate) begin
         beat_ff    <= cmd_ff.beat;
         latched_ff <= cmd_ff.latched;
         updated_ff <= 1'b1;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_beat       = beat_ff;
   assign rsp_latched    = latched_ff;
   assign rsp_updated    = updated_ff;
   assign rsp_interval   = interval_ff;
   assign rsp_bpm        = bpm_ff;
   assign rsp_rate_valid = seen_ff;

endmodule

// ----- design/heart_rate_beat_detector_core.sv -----
// Heart rate beat detector: hysteresis beat detection and bpm x100 rate.
// Path: a sample without a new rate passes the queue and the output register;
// one with a new rate also waits for the 23-step restoring divide in the back end.
// The front end takes one sample per cycle into a 2-entry queue while it is not full;
// the back end takes no new sample while it divides, so the divider sets the rate.
// Reset (synchronous, active high) restores register defaults and clears
// latch, beat history, rate state, queue and the output valid, interval and bpm.
module heart_rate_beat_detector_core #(
   parameter  int SAMPLE_BITS   = 12,
   parameter  int TIME_BITS     = 32,
   localparam int REQ_DATA_BITS = ((SAMPLE_BITS + TIME_BITS + 7) / 8) * 8
) (
   input  logic                               clock,
   input  logic                               reset,
   // tdata: sample, time_ms
   input  logic [REQ_DATA_BITS-1:0]           req_tdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tdata: beat, latched, rate_updated, interval_out_ms, bpm_x100, rate_valid
   output logic [hrbd_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [hrbd_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [hrbd_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import hrbd_pkg::*;

   cfg_type          cfg_ff;
   logic             req_accept;
   logic             push;
   cmd_type          push_cmd;
   logic             pop;
   cmd_type          head;
   queue_status_type qstat;

   logic                     o_beat, o_latched, o_updated, o_seen;
   logic [INTERVAL_BITS-1:0] o_interval;
   logic [QUOT_BITS-1:0]     o_bpm;

   assign csr_ready  = 1'b1;
   assign req_tready = !qstat.full;
   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.upper_threshold <= UPPER_RESET;
         cfg_ff.lower_threshold <= LOWER_RESET;
         cfg_ff.min_interval_ms <= MIN_INT_RESET;
         cfg_ff.max_interval_ms <= MAX_INT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_UPPER_THRESHOLD: cfg_ff.upper_threshold <= csr_wdata[THRESH_BITS-1:0];
            CSR_LOWER_THRESHOLD: cfg_ff.lower_threshold <= csr_wdata[THRESH_BITS-1:0];
            CSR_MIN_INTERVAL:    cfg_ff.min_interval_ms <= csr_wdata;
            CSR_MAX_INTERVAL:    cfg_ff.max_interval_ms <= csr_wdata;
            default: ;
         endcase
      end
   end

   hrbd_front #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .TIME_BITS   (TIME_BITS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_accept),
      .sample  (req_tdata[SAMPLE_BITS-1:0]),
      .time_ms (req_tdata[SAMPLE_BITS +: TIME_BITS]),
      .cfg     (cfg_ff),
      .push    (push),
      .cmd     (push_cmd)
   );

   hrbd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .status   (qstat)
   );

   hrbd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .qstat          (qstat),
      .pop            (pop),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_beat       (o_beat),
      .rsp_latched    (o_latched),
      .rsp_updated    (o_updated),
      .rsp_interval   (o_interval),
      .rsp_bpm        (o_bpm),
      .rsp_rate_valid (o_seen)
   );

   assign rsp_tdata = {5'd0, o_seen, o_bpm, o_interval, o_updated, o_latched, o_beat};

   a_queue_bound : assert property (@(posedge clock) disable iff (reset)
      qstat.count <= QCNT_BITS'(QUEUE_DEPTH))
      else $error("command queue count beyond depth");

   a_no_push_when_full : assert property (@(posedge clock) disable iff (reset)
      qstat.full && !pop |=> $stable(qstat.count))
      else $error("queue count moved while full and not popped");

   a_update_has_beat : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && o_updated |-> o_beat && o_seen)
      else $error("rate update without beat or rate valid");

   a_rate_nonzero : assert property (@(posedge clock) disable iff (reset)
      o_seen |-> o_bpm != '0)
      else $error("valid rate reads zero");

endmodule
